>>> rtl/virtual_timer_pool_core_assert.svh
// Assertion macros for the virtual timer pool core.
// Included by the sequencer and the datapath; no other dependencies.
`ifndef VIRTUAL_TIMER_POOL_CORE_ASSERT_SVH
`define VIRTUAL_TIMER_POOL_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define VTP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VTP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VTP_ASSERT(lbl, clk, rst, prop, msg)
`define VTP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> rtl/vtp_pkg.sv
// Types, codes and microcode table of the virtual timer pool core.
// No dependencies.
package vtp_pkg;

   localparam int MODE_W = 2;
   localparam int IDX_W  = 3;
   localparam int CNT_W  = 16;

   typedef enum logic [MODE_W-1:0] {
      MODE_CREATE = 2'd0,
      MODE_QUERY  = 2'd1,
      MODE_DELETE = 2'd2,
      MODE_TICK   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'd0,
      ST_C_RD = 3'd1,
      ST_C_EV = 3'd2,
      ST_Q_RD = 3'd3,
      ST_Q_EV = 3'd4,
      ST_T_RD = 3'd5,
      ST_T_EV = 3'd6,
      ST_RESP = 3'd7
   } step_type;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_RANGE  = 3'd1,
      EV_CREATE = 3'd2,
      EV_SLOT   = 3'd3,
      EV_TICK   = 3'd4
   } eval_type;

   typedef enum logic [1:0] {
      PTR_HOLD = 2'd0,
      PTR_INC  = 2'd1,
      PTR_DEC  = 2'd2
   } ptr_op_type;

   typedef enum logic [1:0] {
      JMP_DISPATCH = 2'd0,
      JMP_NEXT     = 2'd1,
      JMP_COND     = 2'd2,
      JMP_WAIT     = 2'd3
   } jump_type;

   typedef struct packed {
      logic       rd_en;
      eval_type   eval;
      ptr_op_type ptr_op;
      jump_type   jump;
      logic       load_out;
      step_type   next_step;
      step_type   alt_step;
   } ucode_type;

   typedef struct packed {
      ucode_type uc;
      logic      accept;
   } ctl_bus_type;

   typedef struct packed {
      logic stop;
      logic out_free;
   } dp_sts_type;

   function automatic ucode_type uw(logic rd, eval_type ev, ptr_op_type po,
                                    jump_type jp, logic lo, step_type nx,
                                    step_type alt);
      ucode_type w;
      w.rd_en     = rd;
      w.eval      = ev;
      w.ptr_op    = po;
      w.jump      = jp;
      w.load_out  = lo;
      w.next_step = nx;
      w.alt_step  = alt;
      return w;
   endfunction

   function automatic ucode_type ucode_rom(step_type step);
      ucode_type w;
      case (step)
         ST_IDLE: w = uw(1'b0, EV_NONE,   PTR_HOLD, JMP_DISPATCH, 1'b0, ST_IDLE, ST_IDLE);
         ST_C_RD: w = uw(1'b1, EV_NONE,   PTR_HOLD, JMP_NEXT,     1'b0, ST_C_EV, ST_C_EV);
         ST_C_EV: w = uw(1'b0, EV_CREATE, PTR_DEC,  JMP_COND,     1'b0, ST_RESP, ST_C_RD);
         ST_Q_RD: w = uw(1'b1, EV_RANGE,  PTR_HOLD, JMP_COND,     1'b0, ST_RESP, ST_Q_EV);
         ST_Q_EV: w = uw(1'b0, EV_SLOT,   PTR_HOLD, JMP_NEXT,     1'b0, ST_RESP, ST_RESP);
         ST_T_RD: w = uw(1'b1, EV_NONE,   PTR_HOLD, JMP_NEXT,     1'b0, ST_T_EV, ST_T_EV);
         ST_T_EV: w = uw(1'b0, EV_TICK,   PTR_INC,  JMP_COND,     1'b0, ST_RESP, ST_T_RD);
         ST_RESP: w = uw(1'b0, EV_NONE,   PTR_HOLD, JMP_WAIT,     1'b1, ST_IDLE, ST_IDLE);
         default: w = uw(1'b0, EV_NONE,   PTR_HOLD, JMP_NEXT,     1'b0, ST_IDLE, ST_IDLE);
      endcase
      return w;
   endfunction

   function automatic step_type dispatch(mode_type mode);
      step_type s;
      case (mode)
         MODE_CREATE: s = ST_C_RD;
         MODE_QUERY:  s = ST_Q_RD;
         MODE_DELETE: s = ST_Q_RD;
         MODE_TICK:   s = ST_T_RD;
         default:     s = ST_IDLE;
      endcase
      return s;
   endfunction

endpackage

>>> rtl/vtp_chan_if.sv
// Request and response channel interfaces of the virtual timer pool core.
// Depends on vtp_pkg for field widths.
interface vtp_req_if;
   import vtp_pkg::*;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [IDX_W-1:0]  timer_index;
   logic [CNT_W-1:0]  tick_count;
   modport source (output valid, mode, timer_index, tick_count, input ready);
   modport sink   (input valid, mode, timer_index, tick_count, output ready);
endinterface

interface vtp_rsp_if;
   import vtp_pkg::*;
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] slot_index;
   logic             create_failed;
   logic             is_done;
   modport source (output valid, slot_index, create_failed, is_done, input ready);
   modport sink   (input valid, slot_index, create_failed, is_done, output ready);
endinterface

>>> rtl/vtp_seq.sv
// Microcode sequencer: step counter, control ROM lookup and jump logic.
// Depends on vtp_pkg and virtual_timer_pool_core_assert.svh.
`include "virtual_timer_pool_core_assert.svh"

module vtp_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [vtp_pkg::MODE_W-1:0]  req_mode,
   input  vtp_pkg::dp_sts_type         sts,
   output vtp_pkg::ctl_bus_type        ctl
);
   import vtp_pkg::*;

   step_type step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      ctl.uc     = ucode_rom(step_ff);
      req_ready  = (ctl.uc.jump == JMP_DISPATCH);
      ctl.accept = req_ready && req_valid;
      step_in    = step_ff;
      case (ctl.uc.jump)
         JMP_DISPATCH: begin
            if (ctl.accept) begin
               step_in = dispatch(mode_type'(req_mode));
            end
         end
         JMP_NEXT: step_in = ctl.uc.next_step;
         JMP_COND: step_in = sts.stop ? ctl.uc.next_step : ctl.uc.alt_step;
         JMP_WAIT: begin
            if (sts.out_free) begin
               step_in = ctl.uc.next_step;
            end
         end
         default: step_in = ST_IDLE;
      endcase
   end

   `VTP_ASSERT(a_seq_leave_idle, clock, reset, ctl.accept |=> step_ff != ST_IDLE, "seq: accepted word did not start a program")
   `VTP_ASSERT(a_seq_resp_done, clock, reset, (step_ff == ST_RESP && sts.out_free) |=> step_ff == ST_IDLE, "seq: response step did not return to idle")
   `VTP_ASSERT(a_seq_slot_resp, clock, reset, step_ff == ST_Q_EV |=> step_ff == ST_RESP, "seq: slot step did not go to response")

endmodule

>>> rtl/vtp_dp.sv
// Datapath: slot memory with valid bits, slot pointer, result and output registers.
// Depends on vtp_pkg and virtual_timer_pool_core_assert.svh.
`include "virtual_timer_pool_core_assert.svh"

module vtp_dp #(
   parameter int NUM_TIMERS = 8,
   parameter int TICK_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  vtp_pkg::ctl_bus_type        ctl,
   output vtp_pkg::dp_sts_type         sts,
   input  logic [vtp_pkg::MODE_W-1:0]  req_mode,
   input  logic [vtp_pkg::IDX_W-1:0]   req_timer_index,
   input  logic [vtp_pkg::CNT_W-1:0]   req_tick_count,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [vtp_pkg::IDX_W-1:0]   rsp_slot_index,
   output logic                        rsp_create_failed,
   output logic                        rsp_is_done
);
   import vtp_pkg::*;

   localparam int PW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam logic [PW-1:0]         PTR_LAST  = PW'(NUM_TIMERS - 1);
   localparam logic [TICK_WIDTH-1:0] FREE_MARK = '1;

   logic [TICK_WIDTH-1:0] mem [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] vld_ff;

   mode_type              mode_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [TICK_WIDTH-1:0] cnt_ff;
   logic [PW-1:0]         ptr_ff, ptr_in;
   logic [TICK_WIDTH-1:0] rd_data_ff;
   logic                  rd_vld_ff;
   logic [IDX_W-1:0]      res_slot_ff, res_slot_in;
   logic                  res_fail_ff, res_fail_in;
   logic                  res_done_ff, res_done_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]      rsp_slot_ff;
   logic                  rsp_fail_ff;
   logic                  rsp_done_ff;

   logic [TICK_WIDTH-1:0] rd_val;
   logic                  rd_free, rd_zero, in_range;
   logic                  wr_en, wr_vld;
   logic [TICK_WIDTH-1:0] wr_data;
   logic                  load_out;

   assign rd_val   = rd_vld_ff ? rd_data_ff : FREE_MARK;
   assign rd_free  = (rd_val == FREE_MARK);
   assign rd_zero  = (rd_val == '0);
   assign in_range = (32'(idx_ff) < 32'(NUM_TIMERS));

   always_comb begin
      sts.stop     = 1'b0;
      sts.out_free = !rsp_valid_ff || rsp_ready;
      wr_en        = 1'b0;
      wr_vld       = 1'b1;
      wr_data      = cnt_ff;
      res_slot_in  = res_slot_ff;
      res_fail_in  = res_fail_ff;
      res_done_in  = res_done_ff;
      ptr_in       = ptr_ff;
      case (ctl.uc.eval)
         EV_NONE: ;
         EV_RANGE: sts.stop = !in_range;
         EV_CREATE: begin
            if (rd_free) begin
               wr_en       = 1'b1;
               res_slot_in = IDX_W'(ptr_ff);
               sts.stop    = 1'b1;
            end else if (ptr_ff == '0) begin
               res_fail_in = 1'b1;
               sts.stop    = 1'b1;
            end
         end
         EV_SLOT: begin
            sts.stop = 1'b1;
            if (mode_ff == MODE_QUERY && rd_zero) begin
               wr_en       = 1'b1;
               wr_vld      = 1'b0;
               res_done_in = 1'b1;
            end else if (mode_ff == MODE_DELETE) begin
               wr_en  = 1'b1;
               wr_vld = 1'b0;
            end
         end
         EV_TICK: begin
            sts.stop = (ptr_ff == PTR_LAST);
            if (!rd_zero && !rd_free) begin
               wr_en   = 1'b1;
               wr_data = rd_val - TICK_WIDTH'(1);
            end
         end
         default: ;
      endcase
      if (!sts.stop) begin
         case (ctl.uc.ptr_op)
            PTR_INC:  ptr_in = ptr_ff + PW'(1);
            PTR_DEC:  ptr_in = ptr_ff - PW'(1);
            default:  ptr_in = ptr_ff;
         endcase
      end
      if (ctl.accept) begin
         res_slot_in = '0;
         res_fail_in = 1'b0;
         res_done_in = 1'b0;
         case (mode_type'(req_mode))
            MODE_CREATE: ptr_in = PTR_LAST;
            MODE_TICK:   ptr_in = '0;
            default:     ptr_in = PW'(req_timer_index);
         endcase
      end
   end

   assign load_out = ctl.uc.load_out && sts.out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            vld_ff[ptr_ff] <= wr_vld;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[ptr_ff] <= wr_data;
      end
      if (ctl.uc.rd_en) begin
         rd_data_ff <= mem[ptr_ff];
         rd_vld_ff  <= vld_ff[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         mode_ff <= mode_type'(req_mode);
         idx_ff  <= req_timer_index;
         cnt_ff  <= TICK_WIDTH'(req_tick_count);
      end
      ptr_ff      <= ptr_in;
      res_slot_ff <= res_slot_in;
      res_fail_ff <= res_fail_in;
      res_done_ff <= res_done_in;
      if (load_out) begin
         rsp_slot_ff <= res_slot_ff;
         rsp_fail_ff <= res_fail_ff;
         rsp_done_ff <= res_done_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot_index    = rsp_slot_ff;
   assign rsp_create_failed = rsp_fail_ff;
   assign rsp_is_done       = rsp_done_ff;

   `VTP_ASSERT(a_dp_scan_range, clock, reset, (ctl.uc.eval == EV_CREATE || ctl.uc.eval == EV_TICK) |-> ptr_ff <= PTR_LAST, "dp: scan pointer beyond pool")
   `VTP_ASSERT(a_dp_fail_clean, clock, reset, (rsp_valid_ff && rsp_fail_ff) |-> (rsp_slot_ff == '0 && !rsp_done_ff), "dp: failed create carries slot or done")
   `VTP_ASSERT(a_dp_create_vld, clock, reset, (ctl.uc.eval == EV_CREATE && wr_en) |=> vld_ff[$past(ptr_ff)], "dp: created slot not marked written")
   `VTP_ASSERT_ALWAYS(a_dp_reset_out, clock, reset |=> !rsp_valid_ff, "dp: response word valid after reset")

endmodule

>>> rtl/virtual_timer_pool_core.sv
// Top level of the virtual timer pool core: sequencer and datapath.
// Depends on vtp_pkg, vtp_chan_if, vtp_seq and vtp_dp.
//
//   channel    | direction | word
//   req_chan   | in        | mode, timer_index, tick_count
//   rsp_chan   | out       | slot_index, create_failed, is_done
//
// One word in, one word out. A create or tick walks the slot memory with a read step and
// an evaluate step per slot, followed by the response step. Query and delete read one slot
// and evaluate it unless the index is out of range. Every slot reads free after reset
// through per-slot valid bits. A stalled response is held in the output register while the
// next request word is accepted.
module virtual_timer_pool_core #(
   parameter int NUM_TIMERS = 8,
   parameter int TICK_WIDTH = 16
) (
   input logic      clock,
   input logic      reset,
   vtp_req_if.sink   req_chan,
   vtp_rsp_if.source rsp_chan
);
   import vtp_pkg::*;

   ctl_bus_type ctl;
   dp_sts_type  sts;

   vtp_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_mode  (req_chan.mode),
      .sts       (sts),
      .ctl       (ctl)
   );

   vtp_dp #(
      .NUM_TIMERS (NUM_TIMERS),
      .TICK_WIDTH (TICK_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .req_mode          (req_chan.mode),
      .req_timer_index   (req_chan.timer_index),
      .req_tick_count    (req_chan.tick_count),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_slot_index    (rsp_chan.slot_index),
      .rsp_create_failed (rsp_chan.create_failed),
      .rsp_is_done       (rsp_chan.is_done)
   );

endmodule
